// ===== design/tms_pkg.sv =====
package tms_pkg;

	localparam int TIME_W     = 32;
	localparam int FREQ_W     = 15;
	localparam int DUR_W      = 16;
	localparam int DIV_W      = 20;
	localparam int REPORT_W   = 6;
	localparam int STEP_SHIFT = 12;

	localparam logic [TIME_W-1:0] DEFAULT_CLOCK_HZ = 32'd125000000;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [FREQ_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== design/tone_melody_sequencer_core.sv =====
// Note queue and tone player. Each input item (tick, add note, stop, clear queue) returns
// one status result once its work is done; in_stall stays high meanwhile. Add, stop, clear
// and ticks that find nothing to play go from S_EXEC straight to S_DONE, which loads the
// result register. A tick that plays passes S_CHECK and S_DIV, after S_FIRST when it starts
// the first note; when a note ends and another follows, S_NEXT reads it. A note that starts
// with a nonzero frequency also waits in S_DIVW for the divider. The queue RAM is read one
// entry per cycle: the first note, its duration, then the following note. The tone divider
// (clock_hz / 4096) / frequency comes from a 20-step restoring divider. The next item is
// taken the cycle after its result is loaded. Results wait in an output register, so a new
// item may be taken while the last one is not yet collected. Configuration writes to
// clock_hz apply to the next note that starts.
module tone_melody_sequencer_core #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_wr_en,
	input  logic [tms_pkg::TIME_W-1:0]    cfg_wr_data,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    command,
	input  logic [tms_pkg::TIME_W-1:0]    now_ms,
	input  logic [tms_pkg::FREQ_W-1:0]    note_frequency,
	input  logic [tms_pkg::DUR_W-1:0]     note_duration,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          tone_on,
	output logic [tms_pkg::DIV_W-1:0]     tone_divider,
	output logic                          playing,
	output logic [tms_pkg::REPORT_W-1:0]  queue_count,
	output logic                          queue_full,
	output logic                          note_dropped,
	output logic [tms_pkg::REPORT_W-1:0]  note_position
);

	localparam int AW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW     = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W = tms_pkg::TIME_W;
	localparam int FREQ_W = tms_pkg::FREQ_W;
	localparam int DUR_W  = tms_pkg::DUR_W;
	localparam int DIV_W  = tms_pkg::DIV_W;
	localparam int REP_W  = tms_pkg::REPORT_W;
	localparam int ENT_W  = FREQ_W + DUR_W;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_EXEC  = 8'b0000_0010,
		S_FIRST = 8'b0000_0100,
		S_CHECK = 8'b0000_1000,
		S_NEXT  = 8'b0001_0000,
		S_DIV   = 8'b0010_0000,
		S_DIVW  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [TIME_W-1:0] clock_hz_q;

	tms_pkg::cmd_t     cmd_q;
	logic [TIME_W-1:0] now_q;
	logic [FREQ_W-1:0] freq_q;
	logic [DUR_W-1:0]  dur_q;

	logic [AW-1:0]     wp_q;
	logic [CW-1:0]     held_q;
	logic [CW-1:0]     pos_q;
	logic              playing_q;
	logic              running_q;
	logic [TIME_W-1:0] start_q;
	logic              gen_q;
	logic [DIV_W-1:0]  cur_div_q;
	logic              dropped_q;
	logic              div_pend_q;
	logic [FREQ_W-1:0] div_freq_q;

	logic              out_valid_q;
	logic              tone_on_q;
	logic [DIV_W-1:0]  tone_divider_q;
	logic              playing_out_q;
	logic [REP_W-1:0]  queue_count_q;
	logic              queue_full_q;
	logic              note_dropped_q;
	logic [REP_W-1:0]  note_position_q;

	logic              ram_we;
	logic [AW-1:0]     ram_raddr;
	logic [ENT_W-1:0]  ram_rdata;
	logic [FREQ_W-1:0] rd_freq;
	logic [DUR_W-1:0]  rd_dur;

	logic [CW-1:0]     pos_inc;
	logic              full;
	logic              tick_go;
	logic              first_note;
	logic [TIME_W-1:0] elapsed;
	logic              out_free;

	tms_pkg::div_req_t div_req;
	tms_pkg::div_rsp_t div_rsp;

	assign pos_inc    = pos_q + 1'b1;
	assign full       = (held_q >= CW'(QUEUE_DEPTH));
	assign tick_go    = playing_q && (held_q != '0);
	assign first_note = (pos_q == '0) && !running_q;
	assign elapsed    = now_q - start_q;
	assign rd_freq    = ram_rdata[ENT_W-1:DUR_W];
	assign rd_dur     = ram_rdata[DUR_W-1:0];
	assign out_free   = !out_valid_q || !out_stall;

	assign in_stall = (state_q != S_IDLE);
	assign ram_we   = (state_q == S_EXEC) && (cmd_q == tms_pkg::CMD_ADD) && !full;

	always_comb begin
		unique case (state_q)
			S_EXEC:  ram_raddr = first_note ? '0 : pos_q[AW-1:0];
			S_CHECK: ram_raddr = pos_inc[AW-1:0];
			default: ram_raddr = pos_q[AW-1:0];
		endcase
	end

	assign div_req.start    = (state_q == S_DIV) && div_pend_q;
	assign div_req.dividend = clock_hz_q[TIME_W-1:tms_pkg::STEP_SHIFT];
	assign div_req.divisor  = div_freq_q;

	tms_ram #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(wp_q),
		.wr_data({freq_q, dur_q}),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	tms_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= tms_pkg::DEFAULT_CLOCK_HZ;
		end else if (cfg_wr_en) begin
			clock_hz_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			cmd_q           <= tms_pkg::CMD_TICK;
			now_q           <= '0;
			freq_q          <= '0;
			dur_q           <= '0;
			wp_q            <= '0;
			held_q          <= '0;
			pos_q           <= '0;
			playing_q       <= 1'b0;
			running_q       <= 1'b0;
			start_q         <= '0;
			gen_q           <= 1'b0;
			cur_div_q       <= DIV_W'(1);
			dropped_q       <= 1'b0;
			div_pend_q      <= 1'b0;
			div_freq_q      <= '0;
			out_valid_q     <= 1'b0;
			tone_on_q       <= 1'b0;
			tone_divider_q  <= DIV_W'(1);
			playing_out_q   <= 1'b0;
			queue_count_q   <= '0;
			queue_full_q    <= 1'b0;
			note_dropped_q  <= 1'b0;
			note_position_q <= '0;
		end else begin
			// drop the collected result unless a new one is loaded this cycle
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q      <= tms_pkg::cmd_t'(command);
						now_q      <= now_ms;
						freq_q     <= note_frequency;
						dur_q      <= note_duration;
						dropped_q  <= 1'b0;
						div_pend_q <= 1'b0;
						state_q    <= S_EXEC;
					end
				end

				S_EXEC: begin
					state_q <= S_DONE;
					unique case (cmd_q)
						tms_pkg::CMD_TICK: begin
							if (tick_go && first_note) begin
								state_q <= S_FIRST;
							end else if (tick_go && running_q) begin
								state_q <= S_CHECK;
							end
						end
						tms_pkg::CMD_ADD: begin
							if (full) begin
								dropped_q <= 1'b1;
							end else begin
								wp_q   <= (wp_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
								held_q <= held_q + 1'b1;
								if (!playing_q) begin
									playing_q <= 1'b1;
									pos_q     <= '0;
									running_q <= 1'b0;
								end
							end
						end
						tms_pkg::CMD_STOP: begin
							playing_q <= 1'b0;
							running_q <= 1'b0;
							pos_q     <= '0;
							gen_q     <= 1'b0;
							wp_q      <= '0;
							held_q    <= '0;
						end
						tms_pkg::CMD_CLEAR: begin
							wp_q   <= '0;
							held_q <= '0;
						end
						default: ;
					endcase
				end

				// entry 0 is on the read port: start the first note
				S_FIRST: begin
					start_q   <= now_q;
					running_q <= 1'b1;
					gen_q     <= (rd_freq != '0);
					if (rd_freq != '0) begin
						div_freq_q <= rd_freq;
						div_pend_q <= 1'b1;
					end
					state_q <= S_CHECK;
				end

				S_CHECK: begin
					state_q <= S_DIV;
					if (elapsed >= TIME_W'(rd_dur)) begin
						gen_q     <= 1'b0;
						running_q <= 1'b0;
						if (pos_inc >= held_q) begin
							playing_q <= 1'b0;
							pos_q     <= '0;
							wp_q      <= '0;
							held_q    <= '0;
						end else begin
							pos_q     <= pos_inc;
							start_q   <= now_q;
							running_q <= 1'b1;
							state_q   <= S_NEXT;
						end
					end
				end

				S_NEXT: begin
					gen_q <= (rd_freq != '0);
					if (rd_freq != '0) begin
						div_freq_q <= rd_freq;
						div_pend_q <= 1'b1;
					end
					state_q <= S_DIV;
				end

				S_DIV: begin
					state_q <= div_pend_q ? S_DIVW : S_DONE;
				end

				S_DIVW: begin
					if (div_rsp.done) begin
						cur_div_q <= (div_rsp.quotient == '0) ? DIV_W'(1) : div_rsp.quotient;
						state_q   <= S_DONE;
					end
				end

				S_DONE: begin
					if (out_free) begin
						out_valid_q     <= 1'b1;
						tone_on_q       <= gen_q;
						tone_divider_q  <= cur_div_q;
						playing_out_q   <= playing_q;
						queue_count_q   <= REP_W'(held_q);
						queue_full_q    <= full;
						note_dropped_q  <= dropped_q;
						note_position_q <= REP_W'(pos_q);
						state_q         <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign tone_on       = tone_on_q;
	assign tone_divider  = tone_divider_q;
	assign playing       = playing_out_q;
	assign queue_count   = queue_count_q;
	assign queue_full    = queue_full_q;
	assign note_dropped  = note_dropped_q;
	assign note_position = note_position_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < CW'(QUEUE_DEPTH))
		else $error("play position outside queue");

	a_running_playing: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> playing_q)
		else $error("note running while player idle");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cur_div_q != '0)
		else $error("tone divider dropped to zero");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIVW)
		else $error("divider finished outside its wait state");

endmodule

// ===== design/tms_ram.sv =====
module tms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== design/tms_div.sv =====
module tms_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tms_pkg::div_req_t req,
	output tms_pkg::div_rsp_t rsp
);

	localparam int DIV_W  = tms_pkg::DIV_W;
	localparam int FREQ_W = tms_pkg::FREQ_W;
	localparam int CNT_W  = $clog2(DIV_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]  quo_q;
	logic [FREQ_W:0]   rem_q;
	logic [FREQ_W-1:0] divisor_q;

	logic [FREQ_W:0] rem_sh;
	logic [FREQ_W:0] rem_diff;
	logic            fits;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign rem_sh   = {rem_q[FREQ_W-1:0], quo_q[DIV_W-1]};
	assign fits     = (rem_sh >= {1'b0, divisor_q});
	assign rem_diff = rem_sh - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			divisor_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q    <= 1'b1;
				cnt_q     <= '0;
				quo_q     <= req.dividend;
				rem_q     <= '0;
				divisor_q <= req.divisor;
			end else if (busy_q) begin
				rem_q <= fits ? rem_diff : rem_sh;
				quo_q <= {quo_q[DIV_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== tb/sv/tb_tone_melody_sequencer_core.sv =====
`timescale 1ns / 100ps

module tb_tone_melody_sequencer_core;

	localparam int QUEUE_DEPTH    = 32;
	localparam int SCRIPT_ROWS    = 25;
	localparam int NUM_PHASES     = 6;
	localparam int PHASE_ITEMS    = 125;
	localparam int HOLD_CYCLES    = 300;
	localparam int TAIL_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 10;

	localparam int TIME_W   = tms_pkg::TIME_W;
	localparam int FREQ_W   = tms_pkg::FREQ_W;
	localparam int DUR_W    = tms_pkg::DUR_W;
	localparam int DIV_W    = tms_pkg::DIV_W;
	localparam int REPORT_W = tms_pkg::REPORT_W;

	typedef struct packed {
		logic                tone_on;
		logic [DIV_W-1:0]    divider;
		logic                playing;
		logic [REPORT_W-1:0] count;
		logic                full;
		logic                dropped;
		logic [REPORT_W-1:0] position;
	} player_status_t;

	typedef struct packed {
		tms_pkg::cmd_t     cmd;
		logic [TIME_W-1:0] t;
		logic [FREQ_W-1:0] freq;
		logic [DUR_W-1:0]  len;
		logic              typed;
		player_status_t    want;
	} script_row_t;

	localparam player_status_t IDLE_STATUS = '{1'b0, 20'd1, 1'b0, 6'd0, 1'b0, 1'b0, 6'd0};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [TIME_W-1:0]   cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          command = tms_pkg::CMD_TICK;
	logic [TIME_W-1:0]   now_ms = '0;
	logic [FREQ_W-1:0]   note_frequency = '0;
	logic [DUR_W-1:0]    note_duration = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                tone_on;
	logic [DIV_W-1:0]    tone_divider;
	logic                playing;
	logic [REPORT_W-1:0] queue_count;
	logic                queue_full;
	logic                note_dropped;
	logic [REPORT_W-1:0] note_position;

	// player state as seen from the item stream
	logic [TIME_W-1:0] hz_setting = tms_pkg::DEFAULT_CLOCK_HZ;
	logic [FREQ_W-1:0] note_freq_mem [QUEUE_DEPTH];
	logic [DUR_W-1:0]  note_len_mem [QUEUE_DEPTH];
	int                wr_slot = 0;
	int                notes_held = 0;
	int                play_idx = 0;
	logic              melody_on = 1'b0;
	logic              note_live = 1'b0;
	logic [TIME_W-1:0] note_t0 = '0;
	logic              gen_on = 1'b0;
	logic [DIV_W-1:0]  gen_div = 20'd1;

	player_status_t pending_status [$];
	script_row_t    script [SCRIPT_ROWS];
	logic [TIME_W-1:0] phase_hz [NUM_PHASES] =
		'{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, tms_pkg::DEFAULT_CLOCK_HZ, 32'd48_000_000};

	int   idle_pct = 0;
	int   stall_pct = 0;
	logic hold_on = 1'b0;
	int   mismatches = 0;
	int   results_checked = 0;
	int   items_counted = 0;
	int   notes_started = 0;
	int   notes_refused = 0;
	int   quiet_cycles = 0;

	tone_melody_sequencer_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.now_ms        (now_ms),
		.note_frequency(note_frequency),
		.note_duration (note_duration),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.tone_on       (tone_on),
		.tone_divider  (tone_divider),
		.playing       (playing),
		.queue_count   (queue_count),
		.queue_full    (queue_full),
		.note_dropped  (note_dropped),
		.note_position (note_position)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void load_tone(logic [FREQ_W-1:0] f);
		logic [63:0] q;
		notes_started++;
		if (f == '0) begin
			gen_on = 1'b0;
			return;
		end
		q = {32'd0, hz_setting} / ({49'd0, f} << tms_pkg::STEP_SHIFT);
		if (q == 64'd0)
			q = 64'd1;
		gen_div = q[DIV_W-1:0];
		gen_on = 1'b1;
	endfunction

	function automatic void stop_player();
		melody_on = 1'b0;
		note_live = 1'b0;
		play_idx = 0;
		gen_on = 1'b0;
		wr_slot = 0;
		notes_held = 0;
	endfunction

	function automatic player_status_t player_step(tms_pkg::cmd_t c, logic [TIME_W-1:0] t,
			logic [FREQ_W-1:0] f, logic [DUR_W-1:0] d);
		logic              refused;
		logic [TIME_W-1:0] elapsed;
		player_status_t    s;
		refused = 1'b0;
		case (c)
			tms_pkg::CMD_TICK: begin
				if (melody_on && notes_held != 0) begin
					if (play_idx == 0 && !note_live) begin
						note_t0 = t;
						note_live = 1'b1;
						load_tone(note_freq_mem[0]);
					end
					elapsed = t - note_t0;
					if (note_live && elapsed >= {16'd0, note_len_mem[play_idx % QUEUE_DEPTH]}) begin
						gen_on = 1'b0;
						note_live = 1'b0;
						play_idx++;
						if (play_idx >= notes_held) begin
							stop_player();
						end else begin
							note_t0 = t;
							note_live = 1'b1;
							load_tone(note_freq_mem[play_idx % QUEUE_DEPTH]);
						end
					end
				end
			end
			tms_pkg::CMD_ADD: begin
				if (notes_held >= QUEUE_DEPTH) begin
					refused = 1'b1;
					notes_refused++;
				end else begin
					note_freq_mem[wr_slot] = f;
					note_len_mem[wr_slot] = d;
					wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
					notes_held++;
					if (!melody_on) begin
						melody_on = 1'b1;
						play_idx = 0;
						note_live = 1'b0;
					end
				end
			end
			tms_pkg::CMD_STOP: begin
				stop_player();
			end
			default: begin
				wr_slot = 0;
				notes_held = 0;
			end
		endcase
		s.tone_on = gen_on;
		s.divider = gen_div;
		s.playing = melody_on;
		s.count = notes_held[REPORT_W-1:0];
		s.full = (notes_held >= QUEUE_DEPTH);
		s.dropped = refused;
		s.position = play_idx[REPORT_W-1:0];
		return s;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s expected %0d, got %0d", $realtime, what, want, got);
	endtask

	task automatic send_item(tms_pkg::cmd_t c, logic [TIME_W-1:0] t, logic [FREQ_W-1:0] f,
			logic [DUR_W-1:0] d, logic typed, player_status_t want);
		player_status_t s;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		now_ms <= t;
		note_frequency <= f;
		note_duration <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// ticks on an idle player change nothing; leave them out of the count
		if (!(c == tms_pkg::CMD_TICK && (!melody_on || notes_held == 0)))
			items_counted++;
		s = player_step(c, t, f, d);
		pending_status.push_back(typed ? want : s);
	endtask

	task automatic finish_pending();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_status.size() != 0);
	endtask

	task automatic write_clock(logic [TIME_W-1:0] hz);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= hz;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		hz_setting = hz;
	endtask

	function automatic logic [FREQ_W-1:0] pick_freq();
		case ($urandom_range(5))
			0: return '0;
			1, 2: return FREQ_W'($urandom_range(1, 200));
			default: return FREQ_W'($urandom_range(32767));
		endcase
	endfunction

	function automatic logic [DUR_W-1:0] pick_len();
		if ($urandom_range(9) == 0)
			return DUR_W'($urandom_range(65535));
		return DUR_W'($urandom_range(12));
	endfunction

	task automatic random_melody();
		int                n;
		int                ticks;
		int                cap;
		logic [TIME_W-1:0] t;
		send_item(tms_pkg::CMD_STOP, $urandom, FREQ_W'($urandom_range(32767)),
			DUR_W'($urandom_range(65535)), 1'b0, '0);
		n = ($urandom_range(9) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 6);
		repeat (n)
			send_item(tms_pkg::CMD_ADD, $urandom, pick_freq(), pick_len(), 1'b0, '0);
		// start some melodies just below the wrap of the millisecond clock
		t = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom;
		cap = 4 * n + 8;
		ticks = 0;
		while (melody_on && ticks < cap) begin
			case ($urandom_range(39))
				0: begin
					send_item(tms_pkg::CMD_CLEAR, $urandom, FREQ_W'($urandom_range(32767)),
						DUR_W'($urandom_range(65535)), 1'b0, '0);
				end
				1, 2, 3: begin
					send_item(tms_pkg::CMD_ADD, $urandom, pick_freq(), pick_len(), 1'b0, '0);
				end
				default: begin
					t = t + (($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(15));
					send_item(tms_pkg::CMD_TICK, t, FREQ_W'($urandom_range(32767)),
						DUR_W'($urandom_range(65535)), 1'b0, '0);
				end
			endcase
			ticks++;
		end
	endtask

	task automatic random_traffic(int budget);
		int first;
		first = items_counted;
		while (items_counted - first < budget) begin
			if ($urandom_range(99) < 75) begin
				random_melody();
			end else begin
				repeat ($urandom_range(1, 5))
					send_item(tms_pkg::cmd_t'($urandom_range(3)), $urandom,
						FREQ_W'($urandom_range(32767)), DUR_W'($urandom_range(65535)),
						1'b0, '0);
			end
		end
	endtask

	always @(posedge clk) begin
		player_status_t got;
		player_status_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{tone_on, tone_divider, playing, queue_count, queue_full, note_dropped,
				note_position};
			if (pending_status.size() == 0) begin
				report_mismatch("status transfer with nothing pending, position", 0, got.position);
			end else begin
				want = pending_status.pop_front();
				results_checked++;
				if (got.tone_on !== want.tone_on)
					report_mismatch("tone_on", want.tone_on, got.tone_on);
				if (got.divider !== want.divider)
					report_mismatch("tone_divider", want.divider, got.divider);
				if (got.playing !== want.playing)
					report_mismatch("playing", want.playing, got.playing);
				if (got.count !== want.count)
					report_mismatch("queue_count", want.count, got.count);
				if (got.full !== want.full)
					report_mismatch("queue_full", want.full, got.full);
				if (got.dropped !== want.dropped)
					report_mismatch("note_dropped", want.dropped, got.dropped);
				if (got.position !== want.position)
					report_mismatch("note_position", want.position, got.position);
			end
		end
		out_stall <= hold_on || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		script = '{
			'{tms_pkg::CMD_TICK,  32'd0,         15'd0,    16'd0,    1'b1, IDLE_STATUS},
			'{tms_pkg::CMD_CLEAR, 32'd0,         15'd0,    16'd0,    1'b1, IDLE_STATUS},
			'{tms_pkg::CMD_STOP,  32'd0,         15'd0,    16'd0,    1'b1, IDLE_STATUS},
			'{tms_pkg::CMD_ADD,   32'd0,         15'h7FFF, 16'hFFFF, 1'b1,
				'{1'b0, 20'd1, 1'b1, 6'd1, 1'b0, 1'b0, 6'd0}},
			'{tms_pkg::CMD_ADD,   32'd0,         15'd1,    16'd0,    1'b1,
				'{1'b0, 20'd1, 1'b1, 6'd2, 1'b0, 1'b0, 6'd0}},
			'{tms_pkg::CMD_ADD,   32'd0,         15'd0,    16'd5,    1'b1,
				'{1'b0, 20'd1, 1'b1, 6'd3, 1'b0, 1'b0, 6'd0}},
			// highest frequency floors the divider at one
			'{tms_pkg::CMD_TICK,  32'hFFFF_FFF0, 15'd0,    16'd0,    1'b1,
				'{1'b1, 20'd1, 1'b1, 6'd3, 1'b0, 1'b0, 6'd0}},
			// elapsed time crosses the wrap of the millisecond clock
			'{tms_pkg::CMD_TICK,  32'h0000_FFEF, 15'd0,    16'd0,    1'b0, '0},
			'{tms_pkg::CMD_TICK,  32'h0000_FFEF, 15'd0,    16'd0,    1'b0, '0},
			'{tms_pkg::CMD_TICK,  32'h0000_FFF3, 15'd0,    16'd0,    1'b0, '0},
			'{tms_pkg::CMD_TICK,  32'h0000_FFF4, 15'd0,    16'd0,    1'b0, '0},
			'{tms_pkg::CMD_TICK,  32'hFFFF_FFFF, 15'h7FFF, 16'hFFFF, 1'b0, '0},
			'{tms_pkg::CMD_ADD,   32'd0,         15'd440,  16'd3,    1'b0, '0},
			'{tms_pkg::CMD_ADD,   32'd0,         15'd880,  16'd3,    1'b0, '0},
			'{tms_pkg::CMD_TICK,  32'd100,       15'd0,    16'd0,    1'b0, '0},
			// clear while playing keeps the running note
			'{tms_pkg::CMD_CLEAR, 32'd0,         15'd0,    16'd0,    1'b0, '0},
			'{tms_pkg::CMD_TICK,  32'd200,       15'd0,    16'd0,    1'b0, '0},
			'{tms_pkg::CMD_ADD,   32'd0,         15'd220,  16'd7,    1'b0, '0},
			'{tms_pkg::CMD_ADD,   32'd0,         15'd0,    16'd0,    1'b0, '0},
			'{tms_pkg::CMD_TICK,  32'd201,       15'd0,    16'd0,    1'b0, '0},
			'{tms_pkg::CMD_TICK,  32'd201,       15'd0,    16'd0,    1'b0, '0},
			'{tms_pkg::CMD_ADD,   32'd0,         15'd1000, 16'd50,   1'b0, '0},
			'{tms_pkg::CMD_TICK,  32'd0,         15'd0,    16'd0,    1'b0, '0},
			'{tms_pkg::CMD_STOP,  32'd0,         15'd0,    16'd0,    1'b0, '0},
			'{tms_pkg::CMD_CLEAR, 32'd0,         15'd0,    16'd0,    1'b0, '0}
		};
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_ROWS; i++)
			send_item(script[i].cmd, script[i].t, script[i].freq, script[i].len,
				script[i].typed, script[i].want);

		for (int p = 0; p < NUM_PHASES; p++) begin
			finish_pending();
			write_clock((p == 3) ? $urandom : phase_hz[p]);
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 71;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 71;
				end
				default: begin
					idle_pct = 17;
					stall_pct = 17;
				end
			endcase
			// hold the output side long enough to back up the input
			if (p == 4) begin
				fork
					begin
						hold_on <= 1'b1;
						repeat (HOLD_CYCLES)
							@(posedge clk);
						hold_on <= 1'b0;
					end
				join_none
			end
			random_traffic(PHASE_ITEMS);
		end

		idle_pct = 0;
		stall_pct = 0;
		finish_pending();
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("Run covered %0d items over %0d clock settings, %0d status transfers checked",
			items_counted, NUM_PHASES + 1, results_checked);
		$display("Notes started: %0d, adds refused on a full queue: %0d",
			notes_started, notes_refused);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
